>>> design/sawr_pkg.sv
// Shared types, codes and checksum helper for the stop-and-wait receiver.
package sawr_pkg;

   // Header flag codes, same encoding on receive and transmit.
   localparam logic [2:0] FLAG_SYN     = 3'd0;
   localparam logic [2:0] FLAG_ACK     = 3'd1;
   localparam logic [2:0] FLAG_SYN_ACK = 3'd2;
   localparam logic [2:0] FLAG_OVER    = 3'd3;
   localparam logic [2:0] FLAG_FIN     = 3'd4;
   localparam logic [2:0] FLAG_FIN_ACK = 3'd5;

   // Request kinds carried on tuser.
   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TIMEOUT_TICKS   = 3'd0;
   localparam logic [2:0] CSR_VERIFY_CHECKSUM = 3'd1;
   localparam logic [2:0] CSR_LOCAL_IP        = 3'd2;
   localparam logic [2:0] CSR_PEER_IP         = 3'd3;
   localparam logic [2:0] CSR_LOCAL_PORT      = 3'd4;
   localparam logic [2:0] CSR_PEER_PORT       = 3'd5;

   // Register reset values.
   localparam logic [15:0] RESET_TIMEOUT_TICKS = 16'd10000;
   localparam logic [31:0] RESET_LOCAL_IP      = 32'd2130706433;
   localparam logic [31:0] RESET_PEER_IP       = 32'd2130706433;
   localparam logic [15:0] RESET_LOCAL_PORT    = 16'd8887;
   localparam logic [15:0] RESET_PEER_PORT     = 16'd8888;

   // Width of the response tdata port.
   localparam int RSP_DATA_W = 32;

   // One result; the first member is the highest bits, so send_valid sits at bit 0.
   typedef struct packed {
      logic        closed;
      logic        transfer_done;
      logic        deliver_payload;
      logic [15:0] send_checksum;
      logic        send_fin;
      logic [1:0]  send_ack;
      logic [2:0]  send_flag;
      logic        send_valid;
   } rsp_data_type;

   // One queued result with its end-of-request mark.
   typedef struct packed {
      logic         last;
      rsp_data_type data;
   } rsp_entry_type;

   // Fold a plain sum of 16-bit words with end-around carry and complement it.
   function automatic logic [15:0] cks_fold(input logic [19:0] sum);
      logic [16:0] t;
      logic [15:0] u;
      t = {1'b0, sum[15:0]} + {13'b0, sum[19:16]};
      u = t[15:0] + {15'b0, t[16]};
      return ~u;
   endfunction

endpackage

>>> design/sawr_rsp_fifo.sv
// Result queue that takes up to two results per cycle and drains one per cycle while out_ready is high.
module sawr_rsp_fifo import sawr_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    push_n,
   input  rsp_entry_type push_a,
   input  rsp_entry_type push_b,
   output logic          room,
   output logic          out_valid,
   output rsp_entry_type out_entry,
   input  logic          out_ready
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_entry_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CW-1:0] count_ff, count_in, avail;
   logic          pop;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Handshake and room for a two-result push after this cycle's pop.
   assign out_valid = (count_ff != '0);
   assign out_entry = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign avail     = count_ff - CW'(pop);
   assign room      = (avail <= CW'(DEPTH - 2));
   assign wr_next   = ptr_inc(wr_ptr_ff);

   // Pointer and fill count updates.
   always_comb begin
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push_n)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CW'(push_n) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the second result goes into the slot after the first.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_next] <= push_b;
      end
   end

`ifndef NO_ASSERTIONS
   // A push never overfills the queue.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, avail} + {{(CW-1){1'b0}}, push_n}) <= (CW + 1)'(DEPTH))
      else $error("result queue overflow");
`endif

endmodule

>>> design/stop_and_wait_receiver_fsm.sv
// Top level of the stop-and-wait receiver: input register, phase machine, result queue.
//
// Server side of an alternating-bit connection. Each request is a received header
// (tuser 0) or a timer tick (tuser 1); it is taken into an input register and handled
// once the result queue has room for two results, so a request can be accepted every
// cycle while the queue has room. Results are formed from the input register, queued
// and drained one per cycle while rsp_tready is high; the close step sends ACK, then FIN.
// The depth of the result queue (RSP_DEPTH, at least 2) sets how long the input side
// keeps running while the response side stalls. The user must write configuration
// through the csr_ port only while idle; the block itself does not enforce this.
module stop_and_wait_receiver_fsm import sawr_pkg::*; #(
   parameter int RSP_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: pkt_flag[2:0], pkt_seq, pkt_ack[1:0], pkt_fin, pkt_len[15:0],
   // pkt_checksum[15:0], zero fill.
   input  logic [39:0] req_tdata,
   // tuser: op.
   input  logic        req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: send_valid, send_flag[2:0], send_ack[1:0], send_fin,
   // send_checksum[15:0], deliver_payload, transfer_done, closed, zero fill.
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   // Configuration write port.
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [2:0] {
      PH_WAIT_SYN, PH_WAIT_ACK1, PH_DATA, PH_WAIT_FINACK, PH_WAIT_ACK2, PH_CLOSED
   } phase_type;

   // Configuration registers.
   logic [15:0] timeout_ff;
   logic        verify_ff;
   logic [31:0] local_ip_ff, peer_ip_ff;
   logic [15:0] local_port_ff, peer_port_ff;

   // Input register.
   logic        in_valid_ff;
   logic        in_op_ff;
   logic [2:0]  in_flag_ff;
   logic        in_seq_ff;
   logic [1:0]  in_ack_ff;
   logic        in_fin_ff;
   logic [15:0] in_len_ff;
   logic [15:0] in_cks_ff;

   // Phase machine state.
   phase_type   phase_ff, phase_in;
   logic        expected_ff, expected_in;
   logic [15:0] wait_ff, wait_in;

   logic          consume, room, accept;
   logic [19:0]   base_sum, rx_sum;
   logic          rx_ok;
   logic [1:0]    res_n;
   rsp_entry_type res_a, res_b, out_entry;

   // Build a result that sends a header.
   function automatic rsp_data_type make_hdr(input logic [2:0] flag, input logic [1:0] ack,
                                             input logic fin, input logic deliver,
                                             input logic [19:0] base);
      rsp_data_type d;
      d                 = '0;
      d.send_valid      = 1'b1;
      d.send_flag       = flag;
      d.send_ack        = ack;
      d.send_fin        = fin;
      d.deliver_payload = deliver;
      d.send_checksum   = cks_fold(base + {17'b0, flag} + {18'b0, ack} + {19'b0, fin});
      return d;
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= RESET_TIMEOUT_TICKS;
         verify_ff     <= 1'b1;
         local_ip_ff   <= RESET_LOCAL_IP;
         peer_ip_ff    <= RESET_PEER_IP;
         local_port_ff <= RESET_LOCAL_PORT;
         peer_port_ff  <= RESET_PEER_PORT;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS:   timeout_ff    <= csr_wdata[15:0];
            CSR_VERIFY_CHECKSUM: verify_ff     <= csr_wdata[0];
            CSR_LOCAL_IP:        local_ip_ff   <= csr_wdata;
            CSR_PEER_IP:         peer_ip_ff    <= csr_wdata;
            CSR_LOCAL_PORT:      local_port_ff <= csr_wdata[15:0];
            CSR_PEER_PORT:       peer_port_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // The input register frees up whenever its request moves on.
   assign consume    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || consume;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_tuser;
         in_flag_ff <= req_tdata[2:0];
         in_seq_ff  <= req_tdata[3];
         in_ack_ff  <= req_tdata[5:4];
         in_fin_ff  <= req_tdata[6];
         in_len_ff  <= req_tdata[22:7];
         in_cks_ff  <= req_tdata[38:23];
      end
   end

   // Checksum of the pseudo header words common to every header.
   assign base_sum = {4'b0, local_port_ff} + {4'b0, peer_port_ff}
                   + {4'b0, local_ip_ff[15:0]} + {4'b0, local_ip_ff[31:16]}
                   + {4'b0, peer_ip_ff[15:0]} + {4'b0, peer_ip_ff[31:16]};

   // Check of the received header with its checksum field taken as zero.
   assign rx_sum = base_sum + {4'b0, in_len_ff} + {18'b0, in_ack_ff} + {19'b0, in_seq_ff}
                 + {17'b0, in_flag_ff} + {19'b0, in_fin_ff};
   assign rx_ok  = !verify_ff || (in_cks_ff == cks_fold(rx_sum));

   // Phase machine: next state and the results of the request in the input register.
   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      wait_in     = wait_ff;
      res_n       = 2'd0;
      res_a       = '0;
      res_b       = '0;
      if (consume) begin
         if (in_op_ff == OP_TICK) begin
            if (phase_ff == PH_WAIT_ACK1) begin
               if (wait_ff >= timeout_ff) begin
                  wait_in    = '0;
                  res_a.data = make_hdr(FLAG_SYN_ACK, 2'd1, 1'b0, 1'b0, base_sum);
                  res_n      = 2'd1;
               end else begin
                  wait_in = wait_ff + 16'd1;
               end
            end
         end else begin
            case (phase_ff)
               PH_WAIT_SYN: begin
                  if (in_flag_ff == FLAG_SYN && rx_ok) begin
                     phase_in   = PH_WAIT_ACK1;
                     wait_in    = '0;
                     res_a.data = make_hdr(FLAG_SYN_ACK, 2'd1, 1'b0, 1'b0, base_sum);
                     res_n      = 2'd1;
                  end
               end
               PH_WAIT_ACK1: begin
                  if (in_flag_ff == FLAG_ACK && in_ack_ff == 2'd1 && rx_ok) begin
                     phase_in    = PH_DATA;
                     expected_in = 1'b0;
                  end
               end
               PH_DATA: begin
                  res_n = 2'd1;
                  if (!rx_ok || in_seq_ff != expected_ff) begin
                     // Bad or duplicate header: resend the previous ACK.
                     res_a.data = make_hdr(FLAG_ACK, {1'b0, !expected_ff}, 1'b0, 1'b0,
                                           base_sum);
                  end else if (in_flag_ff == FLAG_OVER) begin
                     phase_in                = PH_WAIT_FINACK;
                     res_a.data.transfer_done = 1'b1;
                  end else begin
                     res_a.data  = make_hdr(FLAG_ACK, {1'b0, expected_ff}, 1'b0, 1'b1,
                                            base_sum);
                     expected_in = !expected_ff;
                  end
               end
               PH_WAIT_FINACK: begin
                  if (in_flag_ff == FLAG_FIN_ACK && in_fin_ff && rx_ok) begin
                     phase_in   = PH_WAIT_ACK2;
                     res_a.data = make_hdr(FLAG_ACK, 2'd1, 1'b0, 1'b0, base_sum);
                     res_b.data = make_hdr(FLAG_FIN, 2'd1, 1'b1, 1'b0, base_sum);
                     res_n      = 2'd2;
                  end
               end
               PH_WAIT_ACK2: begin
                  if (in_flag_ff == FLAG_ACK && in_ack_ff == 2'd2 && rx_ok) begin
                     phase_in          = PH_CLOSED;
                     res_a.data.closed = 1'b1;
                     res_n             = 2'd1;
                  end
               end
               default: ;
            endcase
         end
      end
      // Mark the final result of the request.
      res_a.last = (res_n == 2'd1);
      res_b.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT_SYN;
         expected_ff <= 1'b0;
         wait_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         expected_ff <= expected_in;
         wait_ff     <= wait_in;
      end
   end

   // Result queue feeding the response channel.
   sawr_rsp_fifo #(
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (res_n),
      .push_a    (res_a),
      .push_b    (res_b),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_entry (out_entry),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(rsp_data_type))'(0), out_entry.data};
   assign rsp_tlast = out_entry.last;

`ifndef NO_ASSERTIONS
   // Once closed, the connection stays closed until reset.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLOSED |=> phase_ff == PH_CLOSED)
      else $error("left the closed phase");

   // The alternating bit only changes in the data phase or on entering it.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(expected_ff)) |->
         ($past(phase_ff) == PH_DATA || $past(phase_ff) == PH_WAIT_ACK1))
      else $error("expected bit changed outside the data phase");

   // Results are only produced when a request leaves the input register.
   assert property (@(posedge clock) disable iff (reset)
      !consume |-> res_n == 2'd0)
      else $error("result without a request");

   // The close step is the only source of two results, and it enters the final wait.
   assert property (@(posedge clock) disable iff (reset)
      res_n == 2'd2 |=> phase_ff == PH_WAIT_ACK2)
      else $error("two results outside the close step");
`endif

endmodule
